// File: src/kct_pkg.sv
// Shared types, sizes and reset contents for the keyed credit table.
// Used by kct_cell and keyed_credit_table; depends on nothing else.
package kct_pkg;

  localparam int unsigned ENTRIES   = 8;
  localparam int unsigned KEY_CHARS = 7;

  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned KEY_W   = 56;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned CENTS_W = 16;
  localparam int unsigned CMP_W   = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  localparam logic [MODE_W-1:0] MODE_LOOKUP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REGISTER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHARGE   = 2'd2;

  localparam logic [7:0]  DASH_CHAR      = 8'h2D;
  localparam int unsigned CENTS_PER_UNIT = 100;
  localparam logic [KEY_W-1:0] DASH_KEY  = {7{DASH_CHAR}};

  // Only the leading KEY_CHARS characters (top bytes) take part in a match.
  function automatic logic [KEY_W-1:0] key_mask_f();
    logic [KEY_W-1:0] m;
    m = '0;
    for (int i = 0; i < 7; i++) begin
      if (i < int'(KEY_CHARS)) begin
        m[KEY_W-1-8*i -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  localparam logic [KEY_W-1:0] KEY_MASK = key_mask_f();

  function automatic logic [KEY_W-1:0] reset_key(input int unsigned idx);
    logic [KEY_W-1:0] k;
    case (idx)
      0:       k = "IAC3719";
      1:       k = "IMN0123";
      2:       k = "ISD1A07";
      3:       k = "ICB8720";
      4:       k = "IWE9103";
      5:       k = "IOP1931";
      default: k = DASH_KEY;
    endcase
    return k;
  endfunction

  function automatic logic reset_valid(input int unsigned idx);
    return (idx < 6);
  endfunction

  function automatic logic [CENTS_W-1:0] reset_credit(input int unsigned idx);
    int unsigned c;
    case (idx)
      0:       c = 30 * CENTS_PER_UNIT + 50;
      1:       c = 8  * CENTS_PER_UNIT + 50;
      2:       c = 20 * CENTS_PER_UNIT;
      3:       c = 30 * CENTS_PER_UNIT;
      4:       c = 20 * CENTS_PER_UNIT;
      5:       c = 10 * CENTS_PER_UNIT + 50;
      default: c = 0;
    endcase
    return CENTS_W'(c);
  endfunction

  // Request token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic                vld;
    logic [MODE_W-1:0]   mode;
    logic [KEY_W-1:0]    key;
    logic [SLOT_W-1:0]   slot;
    logic [CENTS_W-1:0]  amount;
    logic                done;
    logic [SLOT_W-1:0]   hit;
    logic                ok;
    logic [CENTS_W-1:0]  bal;
  } tok_t;

endpackage

// File: src/kct_cell.sv
// One table slot: key, valid bit and credit, plus one stage of the request chain.
// Depends on kct_pkg.
module kct_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [kct_pkg::IDX_W-1:0] cell_idx_i,
  input  kct_pkg::tok_t             tok_i,
  output kct_pkg::tok_t             tok_o
);
  import kct_pkg::*;

  logic [KEY_W-1:0]   key_q, key_d;
  logic               valid_q, valid_d;
  logic [CENTS_W-1:0] credit_q, credit_d;
  tok_t               tok_q, tok_d;

  logic key_match, slot_match, covers;

  assign key_match  = valid_q && (((key_q ^ tok_i.key) & KEY_MASK) == '0);
  assign slot_match = (CMP_W'(tok_i.slot) == CMP_W'(cell_idx_i));
  assign covers     = (credit_q >= tok_i.amount);

  always_comb begin
    key_d    = key_q;
    valid_d  = valid_q;
    credit_d = credit_q;
    tok_d    = tok_i;
    if (tok_i.vld && !tok_i.done) begin
      case (tok_i.mode)
        MODE_LOOKUP: begin
          if (key_match) begin
            tok_d.done = 1'b1;
            tok_d.hit  = SLOT_W'(cell_idx_i);
            tok_d.ok   = 1'b1;
          end
        end
        MODE_REGISTER: begin
          if (!valid_q) begin
            key_d      = tok_i.key;
            valid_d    = 1'b1;
            tok_d.done = 1'b1;
            tok_d.hit  = SLOT_W'(cell_idx_i);
            tok_d.ok   = 1'b1;
          end
        end
        MODE_CHARGE: begin
          if (slot_match) begin
            tok_d.done = 1'b1;
            tok_d.hit  = tok_i.slot;
            if (covers) begin
              credit_d  = credit_q - tok_i.amount;
              tok_d.ok  = 1'b1;
              tok_d.bal = credit_q - tok_i.amount;
            end else begin
              tok_d.bal = credit_q;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= reset_key(int'(cell_idx_i));
      valid_q  <= reset_valid(int'(cell_idx_i));
      credit_q <= reset_credit(int'(cell_idx_i));
    end else begin
      key_q    <= key_d;
      valid_q  <= valid_d;
      credit_q <= credit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: src/keyed_credit_table.sv
// Keyed credit table: plate keys and cent balances held in a chain of slot cells.
// Depends on kct_pkg and kct_cell.
// Each request is registered by every cell in turn, then held in the output registers.
// The token walks every cell once, and the block holds a single transaction
// until its result is taken.
// Reset: asynchronous, active low; restores the preloaded plates and clears the rest.
module keyed_credit_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [kct_pkg::MODE_W-1:0]  mode_i,
  input  logic [kct_pkg::KEY_W-1:0]   plate_key_i,
  input  logic [kct_pkg::SLOT_W-1:0]  req_slot_i,
  input  logic [kct_pkg::CENTS_W-1:0] amount_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [kct_pkg::SLOT_W-1:0]  hit_slot_o,
  output logic                        success_o,
  output logic [kct_pkg::CENTS_W-1:0] balance_cents_o
);
  import kct_pkg::*;

  // Token chain: chain[0] is the injected request, chain[ENTRIES] leaves the last cell.
  tok_t chain [ENTRIES+1];

  logic               busy_q, busy_d;
  logic               out_vld_q, out_vld_d;
  logic [SLOT_W-1:0]  hit_q, hit_d;
  logic               ok_q, ok_d;
  logic [CENTS_W-1:0] bal_q, bal_d;
  logic               in_fire, out_fire;
  tok_t               tail;

  // Accept one transaction at a time; hold off until its result is taken.
  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_vld_q && out_ready_i;

  // Inject a fresh token with a cleared result.
  always_comb begin
    chain[0].vld    = in_fire;
    chain[0].mode   = mode_i;
    chain[0].key    = plate_key_i;
    chain[0].slot   = req_slot_i;
    chain[0].amount = amount_i;
    chain[0].done   = 1'b0;
    chain[0].hit    = '0;
    chain[0].ok     = 1'b0;
    chain[0].bal    = '0;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    kct_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(g)),
      .tok_i      (chain[g]),
      .tok_o      (chain[g+1])
    );
  end

  assign tail = chain[ENTRIES];

  // Finish the result: an unclaimed charge names a slot beyond the table, so report
  // the requested slot with failure; lookup/register misses and the unused mode stay zero.
  always_comb begin
    busy_d    = busy_q;
    out_vld_d = out_vld_q;
    hit_d     = hit_q;
    ok_d      = ok_q;
    bal_d     = bal_q;
    if (in_fire) begin
      busy_d = 1'b1;
    end
    if (out_fire) begin
      out_vld_d = 1'b0;
      busy_d    = 1'b0;
    end
    if (tail.vld) begin
      out_vld_d = 1'b1;
      hit_d     = tail.hit;
      ok_d      = tail.ok;
      bal_d     = tail.bal;
      if (!tail.done && (tail.mode == MODE_CHARGE)) begin
        hit_d = tail.slot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Hold the result until the transaction is taken downstream.
  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    ok_q  <= ok_d;
    bal_q <= bal_d;
  end

  assign out_valid_o     = out_vld_q;
  assign hit_slot_o      = hit_q;
  assign success_o       = ok_q;
  assign balance_cents_o = bal_q;

endmodule

// File: tb/keyed_credit_table_tb.sv
// Self-checking testbench for keyed_credit_table: directed table plus random transactions,
// each reply compared against an in-bench model of the plate table and its balances.
// Depends on kct_pkg (sizes, mode codes, dash key) and the keyed_credit_table RTL.
`timescale 1ns / 100ps

module keyed_credit_table_tb;
  import kct_pkg::*;

  // Mode 3 is decoded as a no-op by the block; it still returns an all-zero reply.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // Tail wait after the last reply; one transaction is in flight at a time.
  localparam int unsigned TAIL_CYCLES  = 2 * (ENTRIES + 2);
  // Long receiver hold-off, started once a few hundred replies have been checked.
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [SLOT_W-1:0]  hit;
    logic               ok;
    logic [CENTS_W-1:0] bal;
  } reply_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [KEY_W-1:0]   key;
    logic [SLOT_W-1:0]  slot;
    logic [CENTS_W-1:0] amount;
    bit                 typed;   // reply below is taken as is instead of the model's
    reply_t             reply;
  } request_t;

  localparam logic [KEY_W-1:0] ONES_KEY = {KEY_W{1'b1}};

  // Directed part: reset contents, key and amount extremes, exact and short balances,
  // charges on an empty slot, the unused mode, duplicate registration and a full table.
  localparam int unsigned N_DIRECTED = 24;
  request_t directed_rows [0:N_DIRECTED-1] = '{
    '{MODE_LOOKUP,   "IAC3719", 3'd0, 16'd0,     1'b1, '{3'd0, 1'b1, 16'd0}},
    '{MODE_LOOKUP,   "IOP1931", 3'd7, 16'hFFFF,  1'b1, '{3'd5, 1'b1, 16'd0}},
    '{MODE_LOOKUP,   "IAC3718", 3'd0, 16'd0,     1'b1, '{3'd0, 1'b0, 16'd0}},
    '{MODE_LOOKUP,   DASH_KEY,  3'd0, 16'd0,     1'b1, '{3'd0, 1'b0, 16'd0}},
    '{MODE_LOOKUP,   56'd0,     3'd7, 16'hFFFF,  1'b1, '{3'd0, 1'b0, 16'd0}},
    '{MODE_LOOKUP,   ONES_KEY,  3'd0, 16'd0,     1'b1, '{3'd0, 1'b0, 16'd0}},
    '{MODE_CHARGE,   ONES_KEY,  3'd0, 16'd3050,  1'b1, '{3'd0, 1'b1, 16'd0}},
    '{MODE_CHARGE,   56'd0,     3'd0, 16'd1,     1'b1, '{3'd0, 1'b0, 16'd0}},
    '{MODE_CHARGE,   56'd0,     3'd1, 16'd851,   1'b1, '{3'd1, 1'b0, 16'd850}},
    '{MODE_CHARGE,   56'd0,     3'd1, 16'd50,    1'b1, '{3'd1, 1'b1, 16'd800}},
    '{MODE_CHARGE,   56'd0,     3'd6, 16'd0,     1'b1, '{3'd6, 1'b1, 16'd0}},
    '{MODE_CHARGE,   56'd0,     3'd7, 16'hFFFF,  1'b1, '{3'd7, 1'b0, 16'd0}},
    '{MODE_UNUSED,   ONES_KEY,  3'd7, 16'hFFFF,  1'b1, '{3'd0, 1'b0, 16'd0}},
    '{MODE_REGISTER, "IAC3719", 3'd0, 16'd0,     1'b1, '{3'd6, 1'b1, 16'd0}},
    '{MODE_LOOKUP,   "IAC3719", 3'd1, 16'd0,     1'b1, '{3'd0, 1'b1, 16'd0}},
    '{MODE_REGISTER, ONES_KEY,  3'd0, 16'd0,     1'b1, '{3'd7, 1'b1, 16'd0}},
    '{MODE_REGISTER, "XYZ0001", 3'd0, 16'd0,     1'b1, '{3'd0, 1'b0, 16'd0}},
    '{MODE_LOOKUP,   ONES_KEY,  3'd0, 16'd0,     1'b1, '{3'd7, 1'b1, 16'd0}},
    '{MODE_CHARGE,   56'd0,     3'd7, 16'd0,     1'b1, '{3'd7, 1'b1, 16'd0}},
    '{MODE_CHARGE,   56'd0,     3'd2, 16'd2000,  1'b0, '{3'd0, 1'b0, 16'd0}},
    '{MODE_CHARGE,   56'd0,     3'd4, 16'd1999,  1'b0, '{3'd0, 1'b0, 16'd0}},
    '{MODE_LOOKUP,   "IWE9103", 3'd0, 16'd0,     1'b0, '{3'd0, 1'b0, 16'd0}},
    '{MODE_CHARGE,   56'd0,     3'd3, 16'd3001,  1'b0, '{3'd0, 1'b0, 16'd0}},
    '{MODE_LOOKUP,   "ICB8720", 3'd0, 16'd0,     1'b0, '{3'd0, 1'b0, 16'd0}}
  };

  // DUT signals; every input starts at a known value.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [MODE_W-1:0]  mode_i      = MODE_LOOKUP;
  logic [KEY_W-1:0]   plate_key_i = '0;
  logic [SLOT_W-1:0]  req_slot_i  = '0;
  logic [CENTS_W-1:0] amount_i    = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [SLOT_W-1:0]  hit_slot_o;
  logic               success_o;
  logic [CENTS_W-1:0] balance_cents_o;

  keyed_credit_table uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .plate_key_i     (plate_key_i),
    .req_slot_i      (req_slot_i),
    .amount_i        (amount_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_slot_o      (hit_slot_o),
    .success_o       (success_o),
    .balance_cents_o (balance_cents_o)
  );

  // Model of the table: plates, in-use bits and balances, plus the compare mask.
  logic [KEY_W-1:0]   plate_tab  [ENTRIES];
  logic               slot_used  [ENTRIES];
  logic [CENTS_W-1:0] cents_tab  [ENTRIES];
  logic [KEY_W-1:0]   match_mask;

  reply_t      owed_replies [$];   // replies still due from the block, oldest first
  int unsigned mismatches      = 0;
  int unsigned replies_checked = 0;
  int unsigned cycle_count     = 0;
  int          source_calm     = 0;
  int          sink_calm       = 0;

  initial begin : clock_gen
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop: a hung handshake must not run forever.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Load the reset contents: six preloaded plates, the rest dashes and zero credit.
  function automatic void restore_table();
    logic [KEY_W-1:0]   plates  [6] = '{"IAC3719", "IMN0123", "ISD1A07",
                                        "ICB8720", "IWE9103", "IOP1931"};
    logic [CENTS_W-1:0] credits [6] = '{16'd3050, 16'd850, 16'd2000,
                                        16'd3000, 16'd2000, 16'd1050};
    for (int i = 0; i < ENTRIES; i++) begin
      plate_tab[i] = (i < 6) ? plates[i] : DASH_KEY;
      slot_used[i] = (i < 6);
      cents_tab[i] = (i < 6) ? credits[i] : '0;
    end
    // Compare only the leading KEY_CHARS characters, never more than seven.
    match_mask = '0;
    for (int c = 0; c < 7; c++) begin
      if (c < KEY_CHARS) match_mask[KEY_W-1-8*c -: 8] = 8'hFF;
    end
  endfunction

  // Apply one accepted transaction to the model table and return the reply it owes.
  function automatic reply_t settle_request(request_t req);
    reply_t r;
    r = '0;
    case (req.mode)
      MODE_LOOKUP: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!r.ok && slot_used[i] && ((plate_tab[i] ^ req.key) & match_mask) == '0) begin
            r.hit = SLOT_W'(i);
            r.ok  = 1'b1;
          end
        end
      end
      MODE_REGISTER: begin
        // First free slot takes the full key; its old balance is kept.
        for (int i = 0; i < ENTRIES; i++) begin
          if (!r.ok && !slot_used[i]) begin
            plate_tab[i] = req.key;
            slot_used[i] = 1'b1;
            r.hit = SLOT_W'(i);
            r.ok  = 1'b1;
          end
        end
      end
      MODE_CHARGE: begin
        r.hit = req.slot;
        if (int'(req.slot) < ENTRIES) begin
          if (cents_tab[req.slot] >= req.amount) begin
            cents_tab[req.slot] = cents_tab[req.slot] - req.amount;
            r.ok = 1'b1;
          end
          r.bal = cents_tab[req.slot];
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Random transaction shaped by the current table: mostly keys that are stored
  // and amounts around the balance, with some noise in every field.
  function automatic request_t draw_request();
    request_t req;
    int unsigned pick;
    int unsigned j;
    logic [CENTS_W-1:0] have;
    req.typed  = 1'b0;
    req.reply  = '0;
    req.key    = KEY_W'({$urandom(), $urandom()});
    req.slot   = SLOT_W'($urandom());
    req.amount = CENTS_W'($urandom());
    j    = $urandom_range(0, ENTRIES - 1);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      req.mode = MODE_CHARGE;
      req.slot = SLOT_W'(j);
      have = cents_tab[j];
      pick = $urandom_range(0, 99);
      if (pick < 30)      req.amount = have;
      else if (pick < 55) req.amount = have + 16'd1;
      else if (pick < 85) req.amount = CENTS_W'($urandom_range(0, have));
    end else if (pick < 76) begin
      req.mode = MODE_LOOKUP;
      pick = $urandom_range(0, 99);
      if (pick < 65)      req.key = plate_tab[j];
      else if (pick < 85) req.key = plate_tab[j] ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
    end else if (pick < 94) begin
      req.mode = MODE_REGISTER;
      if ($urandom_range(0, 1)) req.key = plate_tab[j];
    end else begin
      req.mode = MODE_UNUSED;
    end
    return req;
  endfunction

  // Idle length: mostly none, often short, now and then long, with calm stretches.
  function automatic int pick_gap(inout int calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= 100)
      $display("MISMATCH %s: got %0d expected %0d (reply %0d, t=%0t)",
               what, got, want, replies_checked, $realtime);
  endtask

  // Offer one transaction: idle first if the gap says so, then hold valid and the
  // payload until the block takes it, and book the reply it owes.
  task automatic offer(request_t req);
    int gap;
    reply_t due;
    gap = pick_gap(source_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    mode_i      <= req.mode;
    plate_key_i <= req.key;
    req_slot_i  <= req.slot;
    amount_i    <= req.amount;
    in_valid_i  <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    due = settle_request(req);
    owed_replies.push_back(req.typed ? req.reply : due);
  endtask

  // Sender: reset, directed table, random transactions with one full drain pause.
  initial begin : request_source
    int unsigned counted;
    bit drained;
    request_t req;
    counted = 0;
    drained = 1'b0;
    restore_table();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) offer(directed_rows[i]);

    while (counted < RANDOM_ITEMS) begin
      req = draw_request();
      // The no-op mode does not count toward the random budget.
      if (req.mode != MODE_UNUSED) counted++;
      if (!drained && counted == RANDOM_ITEMS / 2) begin
        // Pause the source until every owed reply has come back.
        drained = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (owed_replies.size() != 0);
      end
      offer(req);
    end

    in_valid_i <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk_i);
    // Let a stray extra reply show up before calling it done.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: take replies with random back-pressure, one long hold-off, and compare
  // each accepted reply field by field with the oldest one owed.
  initial begin : reply_sink
    int stall;
    int gap;
    bit held_long;
    reply_t want;
    stall     = 0;
    held_long = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (owed_replies.size() == 0) begin
          flag_mismatch("unexpected reply, hit_slot", hit_slot_o, 0);
        end else begin
          want = owed_replies.pop_front();
          if (hit_slot_o !== want.hit) flag_mismatch("hit_slot", hit_slot_o, want.hit);
          if (success_o !== want.ok) flag_mismatch("success", success_o, want.ok);
          if (balance_cents_o !== want.bal)
            flag_mismatch("balance_cents", balance_cents_o, want.bal);
        end
        replies_checked++;
      end
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (!held_long && replies_checked >= HOLD_AFTER) begin
        // Hold off long enough that the block fills and stalls the source.
        held_long = 1'b1;
        stall = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else begin
        gap = pick_gap(sink_calm);
        if (gap == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          stall = gap - 1;
          out_ready_i <= 1'b0;
        end
      end
    end
  end

endmodule
